// ===== hw/rtl/efla_pkg.sv =====
// ----------------------------------------------------------------------------
// efla_pkg
// Shared types and codes for the extent free-list allocator.
// ----------------------------------------------------------------------------
package efla_pkg;

   typedef enum logic [1:0] {
      REQ_FREE  = 2'd0,
      REQ_ALLOC = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_NOP   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_NOFIT   = 2'd1,
      ST_OVERLAP = 2'd2,
      ST_FULL    = 2'd3
   } status_code_type;

   typedef enum logic [3:0] {
      FS_IDLE,
      FS_SCAN_RD,
      FS_SCAN_CHK,
      FS_DECIDE,
      FS_SHIFT_RD,
      FS_SHIFT_WR,
      FS_WRITE,
      FS_RESP
   } fsm_state_type;

   // memory access request from the controller to the extent table
   typedef struct packed {
      logic        rd;
      logic        wr;
      logic [31:0] wr_first;
      logic [31:0] wr_last;
   } mem_cmd_type;

endpackage

// ===== hw/rtl/efla_table.sv =====
// ----------------------------------------------------------------------------
// efla_table
// Extent table: two 32-bit arrays, one write port and one registered read port.
// ----------------------------------------------------------------------------
module efla_table #(
   parameter int AW = 6
) (
   input  logic                 clock,
   input  efla_pkg::mem_cmd_type cmd,
   input  logic [AW-1:0]        wr_addr,
   input  logic [AW-1:0]        rd_addr,
   output logic [31:0]          rd_first,
   output logic [31:0]          rd_last
);
   import efla_pkg::*;

   logic [31:0] first_mem [2**AW];
   logic [31:0] last_mem  [2**AW];

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         first_mem[wr_addr] <= cmd.wr_first;
         last_mem[wr_addr]  <= cmd.wr_last;
      end
      if (cmd.rd) begin
         rd_first <= first_mem[rd_addr];
         rd_last  <= last_mem[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/extent_free_list_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// extent_free_list_allocator_unit
// First-fit allocator over a sorted table of free extents.
//
//   channel   ports                                   direction
//   request   start, busy, req_*                      in (busy out)
//   result    rsp_valid, rsp_status, rsp_alloc_location out, no stall
//
// A request scans the table one entry at a time (read, then check), then
// shifts entries one at a time (read, then write) for an insert or removal.
// A new request is taken only when idle; busy stays high through the result strobe.
// Reset empties the table at once; the result strobe lasts one cycle.
// ----------------------------------------------------------------------------
module extent_free_list_allocator_unit #(
   parameter int MAX_EXTENTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_range_start,
   input  logic [31:0] req_range_end,
   input  logic [31:0] req_alloc_size,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_alloc_location
);
   import efla_pkg::*;

   localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
   localparam int CW = $clog2(MAX_EXTENTS + 1);
   localparam logic [CW-1:0] CMAX = CW'(MAX_EXTENTS);

   fsm_state_type state_ff, state_in;
   logic [1:0]    op_ff, op_in;
   logic [31:0]   s_ff, s_in, e_ff, e_in, size_ff, size_in;
   logic [CW-1:0] cnt_ff, cnt_in, pos_ff, pos_in, idx_ff, idx_in;
   logic [31:0]   pf_ff, pf_in, pl_ff, pl_in;  // previous extent
   logic [31:0]   nf_ff, nf_in, nl_ff, nl_in;  // next extent
   logic          hn_ff, hn_in;
   logic          shup_ff, shup_in;            // 1: shift up (insert)
   logic [CW-1:0] stop_ff, stop_in;
   logic [CW-1:0] wa_ff, wa_in;
   logic [31:0]   wf_ff, wf_in, wl_ff, wl_in;
   logic [1:0]    st_ff, st_in;
   logic [31:0]   loc_ff, loc_in;

   mem_cmd_type   cmd;
   logic [CW-1:0] ra, wa;
   logic [31:0]   rf, rl;

   efla_table #(.AW(AW)) u_table (
      .clock(clock), .cmd(cmd), .wr_addr(wa[AW-1:0]), .rd_addr(ra[AW-1:0]),
      .rd_first(rf), .rd_last(rl)
   );

   logic [32:0] len;
   logic [32:0] nfirst;
   assign len    = {1'b0, rl} - {1'b0, rf} + 33'd1;
   assign nfirst = {1'b0, rf} + {1'b0, size_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      op_ff <= op_in; s_ff <= s_in; e_ff <= e_in; size_ff <= size_in;
      pos_ff <= pos_in; idx_ff <= idx_in; pf_ff <= pf_in; pl_ff <= pl_in;
      nf_ff <= nf_in; nl_ff <= nl_in; hn_ff <= hn_in; shup_ff <= shup_in;
      stop_ff <= stop_in; wa_ff <= wa_in; wf_ff <= wf_in; wl_ff <= wl_in;
      st_ff <= st_in; loc_ff <= loc_in;
   end

   // next state and datapath
   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; op_in = op_ff; s_in = s_ff;
      e_in = e_ff; size_in = size_ff; pos_in = pos_ff; idx_in = idx_ff;
      pf_in = pf_ff; pl_in = pl_ff; nf_in = nf_ff; nl_in = nl_ff;
      hn_in = hn_ff; shup_in = shup_ff; stop_in = stop_ff; wa_in = wa_ff;
      wf_in = wf_ff; wl_in = wl_ff; st_in = st_ff; loc_in = loc_ff;
      case (state_ff)
         FS_IDLE: begin
            if (start) begin
               op_in = req_type; s_in = req_range_start; e_in = req_range_end;
               size_in = req_alloc_size; idx_in = '0; st_in = ST_DONE;
               loc_in = '0; hn_in = 1'b0;
               case (req_type)
                  REQ_FREE: begin
                     if (req_range_start > req_range_end) begin
                        st_in = ST_OVERLAP; state_in = FS_RESP;
                     end else begin
                        state_in = (cnt_ff == '0) ? FS_DECIDE : FS_SCAN_RD;
                     end
                  end
                  REQ_ALLOC: begin
                     if (cnt_ff == '0) begin
                        st_in = ST_NOFIT; state_in = FS_RESP;
                     end else begin
                        state_in = FS_SCAN_RD;
                     end
                  end
                  REQ_CLEAR: begin
                     cnt_in = '0; state_in = FS_RESP;
                  end
                  default: state_in = FS_RESP;
               endcase
               pos_in = '0;
            end
         end
         FS_SCAN_RD: state_in = FS_SCAN_CHK;
         FS_SCAN_CHK: begin
            if (op_ff == REQ_FREE) begin
               if (s_ff >= rf) begin
                  pf_in = rf; pl_in = rl; pos_in = idx_ff + CW'(1);
                  idx_in = idx_ff + CW'(1);
                  state_in = (idx_ff + CW'(1) == cnt_ff) ? FS_DECIDE : FS_SCAN_RD;
               end else begin
                  nf_in = rf; nl_in = rl; hn_in = 1'b1; state_in = FS_DECIDE;
               end
            end else begin
               if ({1'b0, size_ff} <= len) begin
                  loc_in = rf;
                  if (nfirst > {1'b0, rl}) begin
                     // remove entry idx: shift down
                     shup_in = 1'b0; pos_in = idx_ff; stop_in = cnt_ff - CW'(1);
                     state_in = (idx_ff == cnt_ff - CW'(1)) ? FS_RESP : FS_SHIFT_RD;
                     cnt_in = cnt_ff - CW'(1);
                  end else begin
                     wa_in = idx_ff; wf_in = nfirst[31:0]; wl_in = rl;
                     state_in = FS_WRITE;
                  end
               end else if (idx_ff + CW'(1) == cnt_ff) begin
                  st_in = ST_NOFIT; state_in = FS_RESP;
               end else begin
                  idx_in = idx_ff + CW'(1); state_in = FS_SCAN_RD;
               end
            end
         end
         FS_DECIDE: begin
            if ((hn_ff && e_ff >= nf_ff) || (pos_ff != '0 && s_ff <= pl_ff)) begin
               st_in = ST_OVERLAP; state_in = FS_RESP;
            end else if (pos_ff != '0 && pl_ff != 32'hFFFF_FFFF
                         && pl_ff + 32'd1 == s_ff) begin
               wa_in = pos_ff - CW'(1); wf_in = pf_ff;
               if (hn_ff && e_ff != 32'hFFFF_FFFF && e_ff + 32'd1 == nf_ff) begin
                  wl_in = nl_ff;
                  shup_in = 1'b0; stop_in = cnt_ff - CW'(1);
                  cnt_in = cnt_ff - CW'(1);
                  // write merged prev, then remove pos
                  state_in = FS_WRITE;
               end else begin
                  wl_in = e_ff; state_in = FS_WRITE;
                  stop_in = '0;
               end
            end else if (hn_ff && e_ff != 32'hFFFF_FFFF && e_ff + 32'd1 == nf_ff) begin
               wa_in = pos_ff; wf_in = s_ff; wl_in = nl_ff; stop_in = '0;
               state_in = FS_WRITE;
            end else if (cnt_ff == CMAX) begin
               st_in = ST_FULL; state_in = FS_RESP;
            end else begin
               shup_in = 1'b1; idx_in = cnt_ff; stop_in = '0;
               state_in = (cnt_ff == pos_ff) ? FS_WRITE : FS_SHIFT_RD;
               wa_in = pos_ff; wf_in = s_ff; wl_in = e_ff;
               cnt_in = cnt_ff + CW'(1);
            end
         end
         FS_SHIFT_RD: state_in = FS_SHIFT_WR;
         FS_SHIFT_WR: begin
            if (shup_ff) begin
               idx_in = idx_ff - CW'(1);
               state_in = (idx_ff - CW'(1) == pos_ff) ? FS_WRITE : FS_SHIFT_RD;
            end else begin
               pos_in = pos_ff + CW'(1);
               state_in = (pos_ff + CW'(1) == stop_ff) ? FS_RESP : FS_SHIFT_RD;
            end
         end
         FS_WRITE: begin
            // a bridge merge continues with removal of the next entry
            if (op_ff == REQ_FREE && stop_ff != '0 && !shup_ff
                && stop_ff != pos_ff) begin
               state_in = FS_SHIFT_RD;
            end else begin
               state_in = FS_RESP;
            end
         end
         FS_RESP: state_in = FS_IDLE;
         default: state_in = FS_IDLE;
      endcase
   end

   // table access per state
   always_comb begin
      cmd = '0; ra = idx_ff; wa = wa_ff;
      case (state_ff)
         FS_SCAN_RD: begin
            cmd.rd = 1'b1; ra = idx_ff;
         end
         FS_SHIFT_RD: begin
            cmd.rd = 1'b1;
            ra = shup_ff ? idx_ff - CW'(1) : pos_ff + CW'(1);
         end
         FS_SHIFT_WR: begin
            cmd.wr = 1'b1; cmd.wr_first = rf; cmd.wr_last = rl;
            wa = shup_ff ? idx_ff : pos_ff;
         end
         FS_WRITE: begin
            cmd.wr = 1'b1; cmd.wr_first = wf_ff; cmd.wr_last = wl_ff;
            wa = wa_ff;
         end
         default: cmd = '0;
      endcase
   end

   assign busy               = (state_ff != FS_IDLE);
   assign rsp_valid          = (state_ff == FS_RESP);
   assign rsp_status         = rsp_valid ? st_ff : 2'd0;
   assign rsp_alloc_location = rsp_valid ? loc_ff : 32'd0;

`ifndef ASSERT_OFF
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CMAX) else $error("extent count above capacity");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while idle");
   a_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("request not taken");
`endif

endmodule

// ===== tb/extent_free_list_allocator_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// extent_free_list_allocator_unit_test
// Drives free, allocate, clear and no-op commands into the extent allocator and
// checks every result beat against an in-bench model of the free table.
// ----------------------------------------------------------------------------
module extent_free_list_allocator_unit_test;
   import efla_pkg::*;

   localparam int EXTENTS  = 64;
   localparam int WD_LIMIT = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_type = REQ_NOP;
   logic [31:0] req_range_start = 0;
   logic [31:0] req_range_end = 0;
   logic [31:0] req_alloc_size = 0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_alloc_location;

   extent_free_list_allocator_unit #(.MAX_EXTENTS(EXTENTS)) dut (.*);

   always #10 clock = ~clock;

   typedef struct {
      status_code_type status;
      logic [31:0]     location;
   } grant_type;

   logic [31:0] free_first[EXTENTS];
   logic [31:0] free_last[EXTENTS];
   int          free_count;
   grant_type   pending_grants[$];
   int          mismatches;
   int          watchdog;
   int          send_gap_pct;
   int          beats_sent;

   // ---------------- table model ----------------
   task automatic drop_extent(input int idx);
      for (int i = idx; i + 1 < free_count; i++) begin
         free_first[i] = free_first[i + 1];
         free_last[i]  = free_last[i + 1];
      end
      free_count--;
   endtask

   task automatic model_free(input logic [31:0] s, input logic [31:0] e,
                             output status_code_type st);
      int  pos;
      bit  has_prev, has_next;
      pos = 0;
      if (s > e) begin
         st = ST_OVERLAP;
         return;
      end
      while (pos < free_count && s >= free_first[pos]) pos++;
      has_prev = pos > 0;
      has_next = pos < free_count;
      if ((has_next && e >= free_first[pos]) || (has_prev && s <= free_last[pos - 1])) begin
         st = ST_OVERLAP;
         return;
      end
      st = ST_DONE;
      if (has_prev && {1'b0, free_last[pos - 1]} + 33'd1 == {1'b0, s}) begin
         if (has_next && {1'b0, e} + 33'd1 == {1'b0, free_first[pos]}) begin
            free_last[pos - 1] = free_last[pos];
            drop_extent(pos);
         end else begin
            free_last[pos - 1] = e;
         end
         return;
      end
      if (has_next && {1'b0, e} + 33'd1 == {1'b0, free_first[pos]}) begin
         free_first[pos] = s;
         return;
      end
      if (free_count >= EXTENTS) begin
         st = ST_FULL;
         return;
      end
      for (int i = free_count; i > pos; i--) begin
         free_first[i] = free_first[i - 1];
         free_last[i]  = free_last[i - 1];
      end
      free_first[pos] = s;
      free_last[pos]  = e;
      free_count++;
   endtask

   task automatic model_alloc(input logic [31:0] size, output grant_type g);
      logic [32:0] span, next_first;
      g.status   = ST_NOFIT;
      g.location = 0;
      for (int i = 0; i < free_count; i++) begin
         span = {1'b0, free_last[i]} - {1'b0, free_first[i]} + 33'd1;
         if ({1'b0, size} <= span) begin
            next_first = {1'b0, free_first[i]} + {1'b0, size};
            g.status   = ST_DONE;
            g.location = free_first[i];
            if (next_first > {1'b0, free_last[i]}) drop_extent(i);
            else free_first[i] = next_first[31:0];
            return;
         end
      end
   endtask

   // ---------------- driver ----------------
   // called at a falling edge; busy only moves at rising edges
   task automatic send_beat(input req_code_type op, input logic [31:0] s,
                            input logic [31:0] e, input logic [31:0] size);
      grant_type g;
      while (busy) @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) @(negedge clock);
      req_type        <= op;
      req_range_start <= s;
      req_range_end   <= e;
      req_alloc_size  <= size;
      start           <= 1;
      @(negedge clock);
      start <= 0;
      g.location = 0;
      g.status   = ST_DONE;
      case (op)
         REQ_FREE:  model_free(s, e, g.status);
         REQ_ALLOC: model_alloc(size, g);
         REQ_CLEAR: free_count = 0;
         default: ;
      endcase
      pending_grants.push_back(g);
      beats_sent++;
   endtask

   task automatic drain;
      while (pending_grants.size() != 0) @(negedge clock);
   endtask

   // ---------------- checker ----------------
   always @(posedge clock) begin
      grant_type g;
      if (!reset && rsp_valid) begin
         if (pending_grants.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat status=%0d", rsp_status);
         end else begin
            g = pending_grants.pop_front();
            if (rsp_status !== g.status || rsp_alloc_location !== g.location) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp status=%0d loc=%h got status=%0d loc=%h",
                           g.status, g.location, rsp_status, rsp_alloc_location);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (watchdog >= WD_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------- tests ----------------
   task automatic test_directed;
      send_beat(REQ_ALLOC, 0, 0, 0);
      send_beat(REQ_ALLOC, 0, 0, 5);
      send_beat(REQ_FREE, 100, 199, 0);
      send_beat(REQ_FREE, 150, 160, 0);
      send_beat(REQ_FREE, 50, 40, 0);
      send_beat(REQ_FREE, 300, 399, 0);
      send_beat(REQ_FREE, 200, 299, 0);
      send_beat(REQ_FREE, 90, 99, 0);
      send_beat(REQ_FREE, 400, 409, 0);
      send_beat(REQ_ALLOC, 0, 0, 0);
      send_beat(REQ_ALLOC, 0, 0, 20);
      send_beat(REQ_ALLOC, 0, 0, 10000);
      send_beat(REQ_ALLOC, 0, 0, 32'hFFFF_FFFF);
      send_beat(REQ_FREE, 32'hFFFF_FF00, 32'hFFFF_FFFF, 0);
      send_beat(REQ_FREE, 0, 0, 0);
      send_beat(REQ_FREE, 1, 1, 0);
      send_beat(REQ_ALLOC, 0, 0, 2);
      send_beat(REQ_NOP, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
      send_beat(REQ_CLEAR, 0, 0, 0);
      send_beat(REQ_FREE, 0, 32'hFFFF_FFFF, 0);
      send_beat(REQ_ALLOC, 0, 0, 32'hFFFF_FFFF);
      send_beat(REQ_ALLOC, 0, 0, 1);
      send_beat(REQ_CLEAR, 0, 0, 0);
   endtask

   task automatic test_full_table;
      for (int i = 0; i < EXTENTS + 2; i++)
         send_beat(REQ_FREE, i * 4, i * 4 + 1, 0);
      drain();
      send_beat(REQ_FREE, 2, 2, 0);
      send_beat(REQ_ALLOC, 0, 0, 2);
      send_beat(REQ_CLEAR, 0, 0, 0);
   endtask

   task automatic random_beat;
      logic [31:0] s, e, base;
      int          mode;
      mode = $urandom_range(99);
      base = ($urandom_range(3) == 0) ? $urandom : $urandom_range(4000);
      s = base;
      e = base + $urandom_range(40);
      if (mode < 50) begin
         if ($urandom_range(19) == 0) e = $urandom;
         if ($urandom_range(29) == 0) begin
            s = $urandom;
            e = 32'hFFFF_FFFF;
         end
         send_beat(REQ_FREE, s, e, $urandom);
      end else if (mode < 90) begin
         send_beat(REQ_ALLOC, $urandom, $urandom,
                   ($urandom_range(15) == 0) ? $urandom : $urandom_range(60));
      end else if (mode < 96) begin
         send_beat(REQ_NOP, $urandom, $urandom, $urandom);
      end else begin
         send_beat(REQ_CLEAR, $urandom, $urandom, $urandom);
      end
   endtask

   task automatic test_random(input int count, input int gap_pct);
      send_gap_pct = gap_pct;
      for (int i = 0; i < count; i++) random_beat();
   endtask

   initial begin
      free_count   = 0;
      mismatches   = 0;
      watchdog     = 0;
      beats_sent   = 0;
      send_gap_pct = 6;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      test_full_table();
      test_random(600, 6);
      drain();
      test_random(600, 48);
      test_random(600, 0);
      drain();
      repeat (300) @(negedge clock);
      if (mismatches == 0 && pending_grants.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
